### hw/rtl/bulk_transfer_td_splitter_defines.svh
// Assertion macros for the bulk transfer descriptor splitter.
// Included by RTL files that carry assertions; no other dependencies.
`ifndef BULK_TRANSFER_TD_SPLITTER_DEFINES_SVH
`define BULK_TRANSFER_TD_SPLITTER_DEFINES_SVH
`ifndef SYNTH
`define BTTS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("btts assertion failed");
`define BTTS_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("btts assertion failed");
`else
`define BTTS_ASSERT(lbl, clk, rst_n, prop)
`define BTTS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hw/rtl/btts_pkg.sv
// Shared types and constants for the bulk transfer descriptor splitter.
// No dependencies.
package btts_pkg;
	localparam int MaxTdsDef    = 64;
	localparam int MaxPacketDef = 64;
	localparam int LenW         = 7;
	localparam int PktW         = 10;
	localparam int WordW        = 32;

	typedef enum logic [0:0] {
		ST_IDLE = 1'b0,
		ST_GEN  = 1'b1
	} btts_state_t;

	typedef struct packed {
		logic load;
		logic emit;
	} btts_cmd_t;

	typedef struct packed {
		logic last;
	} btts_sts_t;
endpackage

### hw/rtl/btts_req_if.sv
// Request and descriptor channel interfaces for the descriptor splitter.
// Depends on btts_pkg for field widths.
interface btts_req_if;
	logic                         valid;
	logic                         ready;
	logic                         direction_in;
	logic [6:0]                   dev_addr;
	logic [3:0]                   endpoint_number;
	logic                         low_speed;
	logic [btts_pkg::PktW-1:0]    packet_size;
	logic [btts_pkg::WordW-1:0]   bytes_remaining;
	logic                         toggle_now;
	logic [btts_pkg::WordW-1:0]   buffer_address;

	modport source (output valid, direction_in, dev_addr, endpoint_number, low_speed,
		packet_size, bytes_remaining, toggle_now, buffer_address, input ready);
	modport sink (input valid, direction_in, dev_addr, endpoint_number, low_speed,
		packet_size, bytes_remaining, toggle_now, buffer_address, output ready);
endinterface

interface btts_desc_if;
	logic                         valid;
	logic                         ready;
	logic                         desc_direction_in;
	logic [6:0]                   desc_dev_addr;
	logic [3:0]                   desc_endpoint;
	logic                         desc_low_speed;
	logic                         desc_toggle;
	logic [btts_pkg::LenW-1:0]    desc_length;
	logic [btts_pkg::WordW-1:0]   desc_buffer;
	logic                         irq_on_complete;
	logic                         last_of_run;
	logic                         toggle_after;
	logic [btts_pkg::WordW-1:0]   bytes_left_after;
	logic                         request_error;

	modport source (output valid, desc_direction_in, desc_dev_addr, desc_endpoint,
		desc_low_speed, desc_toggle, desc_length, desc_buffer, irq_on_complete, last_of_run,
		toggle_after, bytes_left_after, request_error, input ready);
	modport sink (input valid, desc_direction_in, desc_dev_addr, desc_endpoint,
		desc_low_speed, desc_toggle, desc_length, desc_buffer, irq_on_complete, last_of_run,
		toggle_after, bytes_left_after, request_error, output ready);
endinterface

### hw/rtl/bulk_transfer_td_splitter.sv
// The first descriptor of a request passes through the request registers and the output register.
// Descriptors: one descriptor per cycle while the output is not stalled; a request yields
// N descriptors (1 to MAX_TDS, 1 on error). A request is taken while the last descriptor
// still waits at the output.
// Reset: arst_n asynchronously clears controller state, datapath registers and output valid.
// Top level of the bulk transfer descriptor splitter; depends on btts_pkg, the interfaces, btts_ctrl and btts_datapath.
module bulk_transfer_td_splitter #(
	parameter int MAX_TDS    = btts_pkg::MaxTdsDef,
	parameter int MAX_PACKET = btts_pkg::MaxPacketDef
) (
	input  logic        clk,
	input  logic        arst_n,
	btts_req_if.sink    req,
	btts_desc_if.source desc
);
	import btts_pkg::*;

	btts_cmd_t cmd;
	btts_sts_t sts;

	btts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (desc.valid),
		.out_ready (desc.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	btts_datapath #(
		.MaxTds    (MAX_TDS),
		.MaxPacket (MAX_PACKET)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.desc   (desc)
	);
endmodule

### hw/rtl/btts_datapath.sv
// Datapath of the descriptor splitter: request registers, step logic, output register.
// Depends on btts_pkg and the channel interfaces in btts_req_if.sv.
module btts_datapath #(
	parameter int MaxTds    = btts_pkg::MaxTdsDef,
	parameter int MaxPacket = btts_pkg::MaxPacketDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  btts_pkg::btts_cmd_t cmd,
	output btts_pkg::btts_sts_t sts,
	btts_req_if.sink            req,
	btts_desc_if.source         desc
);
	import btts_pkg::*;

	localparam int CntW = (MaxTds > 1) ? $clog2(MaxTds) : 1;
	localparam logic [CntW-1:0] LastIdx = CntW'(MaxTds - 1);

	logic               dir_q;
	logic [6:0]         addr_q;
	logic [3:0]         ep_q;
	logic               ls_q;
	logic [LenW-1:0]    ps_q;
	logic [WordW-1:0]   rem_q;
	logic               tog_q;
	logic [WordW-1:0]   buf_q;
	logic [CntW-1:0]    idx_q;
	logic               err_q;

	logic [LenW-1:0]    ps_clamped;
	logic               fits;
	logic               last;
	logic [LenW-1:0]    len;
	logic [WordW-1:0]   left;

	logic               o_dir_q;
	logic [6:0]         o_addr_q;
	logic [3:0]         o_ep_q;
	logic               o_ls_q;
	logic               o_tog_q;
	logic [LenW-1:0]    o_len_q;
	logic [WordW-1:0]   o_buf_q;
	logic               o_irq_q;
	logic               o_last_q;
	logic               o_tog_after_q;
	logic [WordW-1:0]   o_left_q;
	logic               o_err_q;

	assign ps_clamped = (req.packet_size > PktW'(MaxPacket)) ? LenW'(MaxPacket)
		: req.packet_size[LenW-1:0];

	assign fits     = rem_q <= WordW'(ps_q);
	assign last     = err_q || fits || (idx_q == LastIdx);
	assign len      = fits ? rem_q[LenW-1:0] : ps_q;
	assign left     = rem_q - WordW'(len);
	assign sts.last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= 1'b0;
			addr_q <= '0;
			ep_q   <= '0;
			ls_q   <= 1'b0;
			ps_q   <= '0;
			rem_q  <= '0;
			tog_q  <= 1'b0;
			buf_q  <= '0;
			idx_q  <= '0;
			err_q  <= 1'b0;
		end else if (cmd.load) begin
			dir_q  <= req.direction_in;
			addr_q <= req.dev_addr;
			ep_q   <= req.endpoint_number;
			ls_q   <= req.low_speed;
			ps_q   <= ps_clamped;
			rem_q  <= req.bytes_remaining;
			tog_q  <= req.toggle_now;
			buf_q  <= req.buffer_address;
			idx_q  <= '0;
			err_q  <= (ps_clamped == '0) || (req.bytes_remaining == '0);
		end else if (cmd.emit) begin
			rem_q <= left;
			buf_q <= buf_q + WordW'(ps_q);
			tog_q <= ~tog_q;
			idx_q <= idx_q + CntW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_dir_q       <= 1'b0;
			o_addr_q      <= '0;
			o_ep_q        <= '0;
			o_ls_q        <= 1'b0;
			o_tog_q       <= 1'b0;
			o_len_q       <= '0;
			o_buf_q       <= '0;
			o_irq_q       <= 1'b0;
			o_last_q      <= 1'b0;
			o_tog_after_q <= 1'b0;
			o_left_q      <= '0;
			o_err_q       <= 1'b0;
		end else if (cmd.emit) begin
			if (err_q) begin
				o_dir_q       <= 1'b0;
				o_addr_q      <= '0;
				o_ep_q        <= '0;
				o_ls_q        <= 1'b0;
				o_tog_q       <= 1'b0;
				o_len_q       <= '0;
				o_buf_q       <= '0;
				o_irq_q       <= 1'b0;
				o_last_q      <= 1'b1;
				o_tog_after_q <= tog_q;
				o_left_q      <= rem_q;
				o_err_q       <= 1'b1;
			end else begin
				o_dir_q       <= dir_q;
				o_addr_q      <= addr_q;
				o_ep_q        <= ep_q;
				o_ls_q        <= ls_q;
				o_tog_q       <= tog_q;
				o_len_q       <= len;
				o_buf_q       <= buf_q;
				o_irq_q       <= last;
				o_last_q      <= last;
				o_tog_after_q <= last & ~tog_q;
				o_left_q      <= last ? left : '0;
				o_err_q       <= 1'b0;
			end
		end
	end

	assign desc.desc_direction_in   = o_dir_q;
	assign desc.desc_dev_addr       = o_addr_q;
	assign desc.desc_endpoint       = o_ep_q;
	assign desc.desc_low_speed      = o_ls_q;
	assign desc.desc_toggle         = o_tog_q;
	assign desc.desc_length         = o_len_q;
	assign desc.desc_buffer         = o_buf_q;
	assign desc.irq_on_complete     = o_irq_q;
	assign desc.last_of_run         = o_last_q;
	assign desc.toggle_after        = o_tog_after_q;
	assign desc.bytes_left_after    = o_left_q;
	assign desc.request_error       = o_err_q;
endmodule

### hw/rtl/btts_ctrl.sv
// Controller of the descriptor splitter: request/descriptor handshakes and sequencing.
// Depends on btts_pkg and bulk_transfer_td_splitter_defines.svh.
`include "bulk_transfer_td_splitter_defines.svh"
module btts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  btts_pkg::btts_sts_t sts,
	output btts_pkg::btts_cmd_t cmd
);
	import btts_pkg::*;

	btts_state_t state_q, state_d;
	logic        out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_GEN;
			end
			ST_GEN: begin
				if (cmd.emit && sts.last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_GEN: begin
				cmd.emit = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`BTTS_ASSERT(a_load_then_gen, clk, arst_n, cmd.load |=> state_q == ST_GEN)
	`BTTS_ASSERT(a_emit_fills_out, clk, arst_n, cmd.emit |=> out_valid_q)
	`BTTS_ASSERT(a_stall_holds, clk, arst_n, out_valid_q && !out_ready && !cmd.emit |=> out_valid_q)
	`BTTS_ASSERT_ALWAYS(a_load_emit_excl, clk, !(cmd.load && cmd.emit))
endmodule
